FILE: rtl/spqvs_pkg.sv
// Shared types, constants and divider helpers for the sprite quad vertex setup.
// Used by spqvs_tile_uv and sprite_quad_vertex_setup; no dependencies.
package spqvs_pkg;

  localparam int IN_TDATA_W   = 152;
  localparam int OUT_TDATA_W  = 128;
  localparam int CORNER_COUNT = 4;
  localparam int PIPE_DEPTH   = 8;

  localparam logic        MODE_FLIP = 1'b0;
  localparam logic        MODE_TILE = 1'b1;
  localparam logic        CFG_SCALE_X = 1'b0;
  localparam logic        CFG_SCALE_Y = 1'b1;
  localparam logic [15:0] SCALE_ONE = 16'd4096;
  localparam logic [23:0] UV_ONE    = 24'd65536;
  localparam logic [23:0] UV_MAX    = 24'hFFFFFF;

  // restoring divider state: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [6:0]  rem;
    logic [31:0] num;
  } div_st_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  corner;
    logic        flip_h;
    logic        flip_v;
    logic [6:0]  tiles_x;
    logic [6:0]  tiles_y;
    logic [11:0] tile_index;
  } uv_req_t;

  function automatic div_st_t div_step(div_st_t s, logic [6:0] d);
    logic [7:0] t;
    div_st_t    r;
    t     = {s.rem, s.num[31]};
    r.num = {s.num[30:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem    = 7'(t - {1'b0, d});
      r.num[0] = 1'b1;
    end else begin
      r.rem = t[6:0];
    end
    return r;
  endfunction

  // up to six steps per pipeline stage
  function automatic div_st_t div_steps(div_st_t s, logic [6:0] d, int n);
    div_st_t r;
    r = s;
    for (int i = 0; i < 6; i++) begin
      if (i < n) r = div_step(r, d);
    end
    return r;
  endfunction

endpackage

FILE: rtl/spqvs_tile_uv.sv
// Texture coordinate pipeline: flip mode and atlas tile rectangle per corner.
// Eight stages advancing on adv; depends on spqvs_pkg.
module spqvs_tile_uv (
  input  logic              clk,
  input  logic              adv,
  input  spqvs_pkg::uv_req_t req,
  output logic [23:0]       tex_u,
  output logic [23:0]       tex_v
);

  spqvs_pkg::uv_req_t req_fx;
  spqvs_pkg::uv_req_t rq_r [1:7];
  spqvs_pkg::div_st_t a1_r, a2_r;
  spqvs_pkg::div_st_t u3_r, u4_r, u5_r, u6_r, u7_r;
  spqvs_pkg::div_st_t v3_r, v4_r, v5_r, v6_r, v7_r;
  spqvs_pkg::div_st_t a_init, u_init, v_init;
  logic [6:0]  nu;
  logic [12:0] nv;
  logic [23:0] u_nxt, v_nxt;
  logic [23:0] u_q;
  logic [29:0] v_q;

  always_comb begin
    req_fx = req;
    // zero tile count behaves as one
    if (req.tiles_x == 7'd0) req_fx.tiles_x = 7'd1;
    if (req.tiles_y == 7'd0) req_fx.tiles_y = 7'd1;
    a_init = '{rem: 7'd0, num: {req_fx.tile_index, 20'd0}};
    // col = remainder, row = quotient of tile_index / tiles_x
    nu = a2_r.rem + 7'(rq_r[2].corner[0]);
    nv = a2_r.num[12:0] + 13'(rq_r[2].corner[1]);
    u_init = '{rem: 7'd0, num: {nu, 16'd0, 9'd0}};
    v_init = '{rem: 7'd0, num: {nv, 16'd0, 3'd0}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rq_r[1] <= req_fx;
      for (int i = 2; i <= 7; i++) rq_r[i] <= rq_r[i-1];
      a1_r <= spqvs_pkg::div_steps(a_init, req_fx.tiles_x, 6);
      a2_r <= spqvs_pkg::div_steps(a1_r, rq_r[1].tiles_x, 6);
      u3_r <= spqvs_pkg::div_steps(u_init, rq_r[2].tiles_x, 6);
      v3_r <= spqvs_pkg::div_steps(v_init, rq_r[2].tiles_y, 6);
      u4_r <= spqvs_pkg::div_steps(u3_r, rq_r[3].tiles_x, 6);
      v4_r <= spqvs_pkg::div_steps(v3_r, rq_r[3].tiles_y, 6);
      u5_r <= spqvs_pkg::div_steps(u4_r, rq_r[4].tiles_x, 6);
      v5_r <= spqvs_pkg::div_steps(v4_r, rq_r[4].tiles_y, 6);
      u6_r <= spqvs_pkg::div_steps(u5_r, rq_r[5].tiles_x, 5);
      v6_r <= spqvs_pkg::div_steps(v5_r, rq_r[5].tiles_y, 6);
      u7_r <= u6_r;
      v7_r <= spqvs_pkg::div_steps(v6_r, rq_r[6].tiles_y, 5);
      tex_u <= u_nxt;
      tex_v <= v_nxt;
    end
  end

  // round to nearest: bump the quotient when twice the remainder reaches the divisor
  always_comb begin
    u_q = {1'b0, u7_r.num[22:0]} + 24'({u7_r.rem, 1'b0} >= {1'b0, rq_r[7].tiles_x});
    v_q = {1'b0, v7_r.num[28:0]} + 30'({v7_r.rem, 1'b0} >= {1'b0, rq_r[7].tiles_y});
    if (rq_r[7].mode == spqvs_pkg::MODE_TILE) begin
      u_nxt = u_q;
      v_nxt = (v_q > 30'(spqvs_pkg::UV_MAX)) ? spqvs_pkg::UV_MAX : v_q[23:0];
    end else begin
      u_nxt = (rq_r[7].corner[0] ^ rq_r[7].flip_h) ? spqvs_pkg::UV_ONE : 24'd0;
      v_nxt = (rq_r[7].corner[1] ^ rq_r[7].flip_v) ? spqvs_pkg::UV_ONE : 24'd0;
    end
  end

endmodule

FILE: rtl/sprite_quad_vertex_setup.sv
// Sprite quad vertex setup: one sprite in, four corners out. A sprite is held in
// an input register and issued as one corner per cycle, while adv is high, into
// an 8-stage pipeline; a new sprite is taken as the held one issues its last corner.
// A corner reaches out_* through the hold register and then the pipeline stages.
// Reset (sync, rst_n low): pipeline emptied, scale_x and scale_y set to 1.0.
// Depends on spqvs_pkg and spqvs_tile_uv.
module sprite_quad_vertex_setup #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [15:0]                       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, width, height, angle, color, flip_h, flip_v, tiles_x, tiles_y,
  // tile_index, zero pad
  input  logic [spqvs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vert_x, vert_y, tex_u, tex_v, vert_color
  output logic [spqvs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                        out_tuser,  // corner
  output logic                              out_tlast
);

  localparam int  KW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int  PD = spqvs_pkg::PIPE_DEPTH;
  localparam real HALF_PI = 1.5707963267948966;
  localparam real STEP_ANGLE = HALF_PI / real'(SINE_TABLE_DEPTH);

  typedef logic [15:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    real       a;
    int        e;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      a = 32768.0 * $sin(STEP_ANGLE * real'(i));
      e = int'($floor(a + 0.5));
      if (e > 32768) e = 32768;
      t[i] = 16'(e);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [15:0] scale_x_r, scale_y_r;

  // input hold register
  logic        h_vld_r;
  logic [1:0]  h_cnt_r;
  logic        h_type_r, h_fh_r, h_fv_r;
  logic signed [19:0] h_px_r, h_py_r;
  logic [15:0] h_w_r, h_h_r, h_ang_r;
  logic [31:0] h_color_r;
  logic [6:0]  h_tx_r, h_ty_r;
  logic [11:0] h_idx_r;

  logic adv, h_fire, in_fire;

  logic        vld_r [1:PD];
  logic [1:0]  crn_r [1:PD];
  logic [31:0] col_r [1:PD];

  // position path
  logic [31:0] hx1_r, hy1_r, hx2_r, hy2_r;
  logic signed [36:0] cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r;
  logic [KW-1:0] k1_r;
  logic [1:0]  q1_r;
  logic [31:0] kfull;
  logic [KW-1:0] addr_s, addr_c;
  logic [15:0] sin2_r, cos2_r;
  logic        negs2_r, negc2_r;
  logic signed [16:0] sn, cs;
  logic signed [32:0] lx, ly;
  logic signed [49:0] mxc3_r, mys3_r, mxs3_r, myc3_r;
  logic signed [55:0] sx4_r, sy4_r;
  logic signed [27:0] rx, ry;
  logic [23:0] vx_r [5:PD];
  logic [23:0] vy_r [5:PD];
  logic [23:0] tex_u, tex_v;

  spqvs_pkg::uv_req_t uv_req;

  assign adv       = !vld_r[PD] || out_tready;
  assign h_fire    = h_vld_r && adv;
  assign in_tready = !h_vld_r || (adv && h_cnt_r == 2'(spqvs_pkg::CORNER_COUNT - 1));
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= spqvs_pkg::SCALE_ONE;
      scale_y_r <= spqvs_pkg::SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        spqvs_pkg::CFG_SCALE_X: scale_x_r <= cfg_wdata;
        spqvs_pkg::CFG_SCALE_Y: scale_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      h_cnt_r <= 2'd0;
    end else begin
      if (in_fire) begin
        h_vld_r <= 1'b1;
        h_cnt_r <= 2'd0;
      end else if (h_fire) begin
        if (h_cnt_r == 2'(spqvs_pkg::CORNER_COUNT - 1)) h_vld_r <= 1'b0;
        h_cnt_r <= h_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      h_type_r  <= in_tuser;
      h_px_r    <= in_tdata[19:0];
      h_py_r    <= in_tdata[39:20];
      h_w_r     <= in_tdata[55:40];
      h_h_r     <= in_tdata[71:56];
      h_ang_r   <= in_tdata[87:72];
      h_color_r <= in_tdata[119:88];
      h_fh_r    <= in_tdata[120];
      h_fv_r    <= in_tdata[121];
      h_tx_r    <= in_tdata[128:122];
      h_ty_r    <= in_tdata[135:129];
      h_idx_r   <= in_tdata[147:136];
    end
  end

  // valid, corner and color travel down the pipe together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= PD; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= h_vld_r;
      for (int i = 2; i <= PD; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crn_r[1] <= h_cnt_r;
      col_r[1] <= h_color_r;
      for (int i = 2; i <= PD; i++) begin
        crn_r[i] <= crn_r[i-1];
        col_r[i] <= col_r[i-1];
      end
    end
  end

  assign kfull = ((32'(h_ang_r[13:0]) * 32'(SINE_TABLE_DEPTH)) + 32'd8192) >> 14;

  // quadrant fold: the sine read runs backwards in odd quadrants, the cosine read in even ones
  assign addr_s = q1_r[0] ? KW'(SINE_TABLE_DEPTH) - k1_r : k1_r;
  assign addr_c = q1_r[0] ? k1_r : KW'(SINE_TABLE_DEPTH) - k1_r;

  always_comb begin
    sn = negs2_r ? -$signed({1'b0, sin2_r}) : $signed({1'b0, sin2_r});
    cs = negc2_r ? -$signed({1'b0, cos2_r}) : $signed({1'b0, cos2_r});
    lx = crn_r[2][0] ? $signed({1'b0, hx2_r}) : -$signed({1'b0, hx2_r});
    ly = crn_r[2][1] ? $signed({1'b0, hy2_r}) : -$signed({1'b0, hy2_r});
    rx = sx4_r[55:28];
    ry = sy4_r[55:28];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: scaling and table index
      hx1_r <= h_w_r * scale_x_r;
      hy1_r <= h_h_r * scale_x_r;
      cx1_r <= h_px_r * $signed({1'b0, scale_x_r});
      cy1_r <= h_py_r * $signed({1'b0, scale_y_r});
      k1_r  <= kfull[KW-1:0];
      q1_r  <= h_ang_r[15:14];
      // stage 2: sine table reads
      sin2_r  <= SINE_ROM[addr_s];
      cos2_r  <= SINE_ROM[addr_c];
      negs2_r <= q1_r[1];
      negc2_r <= q1_r[1] ^ q1_r[0];
      hx2_r   <= hx1_r;
      hy2_r   <= hy1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      // stage 3: rotation products
      mxc3_r <= lx * cs;
      mys3_r <= ly * sn;
      mxs3_r <= lx * sn;
      myc3_r <= ly * cs;
      cx3_r  <= cx2_r;
      cy3_r  <= cy2_r;
      // stage 4: sum with centre and rounding offset
      sx4_r <= 56'(mxc3_r) - 56'(mys3_r) + (56'(cx3_r) <<< 16) + 56'sd134217728;
      sy4_r <= 56'(mxs3_r) + 56'(myc3_r) + (56'(cy3_r) <<< 16) + 56'sd134217728;
      // stage 5: saturate
      if (rx > 28'sd8388607)       vx_r[5] <= 24'h7FFFFF;
      else if (rx < -28'sd8388608) vx_r[5] <= 24'h800000;
      else                         vx_r[5] <= rx[23:0];
      if (ry > 28'sd8388607)       vy_r[5] <= 24'h7FFFFF;
      else if (ry < -28'sd8388608) vy_r[5] <= 24'h800000;
      else                         vy_r[5] <= ry[23:0];
      for (int i = 6; i <= PD; i++) begin
        vx_r[i] <= vx_r[i-1];
        vy_r[i] <= vy_r[i-1];
      end
    end
  end

  assign uv_req = '{mode: h_type_r, corner: h_cnt_r, flip_h: h_fh_r, flip_v: h_fv_r,
                    tiles_x: h_tx_r, tiles_y: h_ty_r, tile_index: h_idx_r};

  spqvs_tile_uv u_tile_uv (
    .clk   (clk),
    .adv   (adv),
    .req   (uv_req),
    .tex_u (tex_u),
    .tex_v (tex_v)
  );

  assign out_tvalid = vld_r[PD];
  assign out_tdata  = {col_r[PD], tex_v, tex_u, vy_r[PD], vx_r[PD]};
  assign out_tuser  = crn_r[PD];
  assign out_tlast  = crn_r[PD] == 2'(spqvs_pkg::CORNER_COUNT - 1);

`ifndef NO_ASSERTIONS
  // corners of a sprite leave back to back, in order
  a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tuser == $past(out_tuser) + 2'd1)
    else $error("corner sequence broken");

  // an idle hold register always restarts at the first corner
  a_hold_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !h_vld_r |-> h_cnt_r == 2'd0)
    else $error("corner counter not cleared");

  // a new sprite is taken only when the held one issues its last corner
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && h_vld_r |-> h_fire && h_cnt_r == 2'd3)
    else $error("held sprite overwritten");
`endif

endmodule
